// ===== rtl/cse_pkg.sv =====
// Shared types and constants for the cosine similarity engine.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cse_pkg;

    // Longest vector the block handles; longer lengths are clamped to this.
    localparam int MAX_DIM = 512;

    localparam int LEN_W    = 10;                    // vector_length register width
    localparam int CNT_W    = $clog2(MAX_DIM);       // pair counter width
    localparam int CMP_W    = (CNT_W + 1 > LEN_W) ? CNT_W + 1 : LEN_W;
    localparam int ELEM_W   = 16;
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int ACC_W    = 40;
    localparam int ROOT_W   = ACC_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int DIV_W    = ACC_W + 1;
    localparam int QUOT_W   = 15;
    localparam int SIM_W    = 16;
    localparam int STEP_W   = 5;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(512);
    localparam logic [SIM_W-1:0] Q14_ONE   = SIM_W'(16384);

    localparam logic signed [ACC_W-1:0] DOT_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] DOT_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0]        NORM_MAX = {ACC_W{1'b1}};

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_VECTOR_LENGTH = 1'b0;   // register index, paddr[2]

    // One finished vector handed from the accumulator to the back end.
    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic [ACC_W-1:0]        norm_a;
        logic [ACC_W-1:0]        norm_b;
    } cse_vec_t;

endpackage

`default_nettype wire

// ===== rtl/cse_front.sv =====
// Front end: takes element pairs, multiplies and accumulates dot and norms.
// Pushes the saturated sums of each finished vector into the queue; uses cse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cse_front
    import cse_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic signed [ELEM_W-1:0] elem_a,
    input  wire logic signed [ELEM_W-1:0] elem_b,
    input  wire logic [LEN_W-1:0]         vector_length,
    output logic                          q_push,
    output cse_vec_t                      q_data,
    input  wire logic                     q_full
);

    logic                      prod_valid_reg;
    logic                      prod_last_reg;
    logic signed [PROD_W-1:0]  prod_ab_reg;
    logic [PROD_W-1:0]         prod_aa_reg;
    logic [PROD_W-1:0]         prod_bb_reg;

    logic [CNT_W-1:0]          count_reg;
    logic signed [ACC_W-1:0]   dot_reg;
    logic [ACC_W-1:0]          norm_a_reg;
    logic [ACC_W-1:0]          norm_b_reg;

    logic [CMP_W-1:0]          eff_len;
    logic [CMP_W-1:0]          count_plus;
    logic                      last;
    logic                      accept;
    logic                      consume;
    logic signed [ACC_W:0]     dot_sum;
    logic [ACC_W:0]            na_sum;
    logic [ACC_W:0]            nb_sum;
    logic signed [ACC_W-1:0]   dot_next;
    logic [ACC_W-1:0]          norm_a_next;
    logic [ACC_W-1:0]          norm_b_next;
    logic signed [PROD_W-1:0]  aa_s;
    logic signed [PROD_W-1:0]  bb_s;

    // Zero length acts as one, long lengths clamp to the maximum
    always_comb
    begin
        priority if (vector_length == '0)
        begin
            eff_len = CMP_W'(1);
        end
        else if (CMP_W'(vector_length) > CMP_W'(MAX_DIM))
        begin
            eff_len = CMP_W'(MAX_DIM);
        end
        else
        begin
            eff_len = CMP_W'(vector_length);
        end
    end

    assign count_plus = CMP_W'(count_reg) + CMP_W'(1);
    assign last       = (count_plus >= eff_len);

    assign consume = prod_valid_reg && !(prod_last_reg && q_full);
    assign full    = prod_valid_reg && !consume;
    assign accept  = push && !full;

    assign aa_s = elem_a * elem_a;
    assign bb_s = elem_b * elem_b;

    // Saturating accumulation
    assign dot_sum = {dot_reg[ACC_W-1], dot_reg} + (ACC_W+1)'(prod_ab_reg);
    assign na_sum  = {1'b0, norm_a_reg} + (ACC_W+1)'(prod_aa_reg);
    assign nb_sum  = {1'b0, norm_b_reg} + (ACC_W+1)'(prod_bb_reg);

    always_comb
    begin
        priority if (dot_sum > (ACC_W+1)'(DOT_MAX))
        begin
            dot_next = DOT_MAX;
        end
        else if (dot_sum < (ACC_W+1)'(DOT_MIN))
        begin
            dot_next = DOT_MIN;
        end
        else
        begin
            dot_next = dot_sum[ACC_W-1:0];
        end
        norm_a_next = na_sum[ACC_W] ? NORM_MAX : na_sum[ACC_W-1:0];
        norm_b_next = nb_sum[ACC_W] ? NORM_MAX : nb_sum[ACC_W-1:0];
    end

    assign q_push        = consume && prod_last_reg;
    assign q_data.dot    = dot_next;
    assign q_data.norm_a = norm_a_next;
    assign q_data.norm_b = norm_b_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            count_reg      <= '0;
            dot_reg        <= '0;
            norm_a_reg     <= '0;
            norm_b_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                prod_valid_reg <= 1'b1;
                prod_last_reg  <= last;
                count_reg      <= last ? '0 : count_plus[CNT_W-1:0];
            end
            else if (consume)
            begin
                prod_valid_reg <= 1'b0;
            end
            if (consume)
            begin
                if (prod_last_reg)
                begin
                    dot_reg    <= '0;
                    norm_a_reg <= '0;
                    norm_b_reg <= '0;
                end
                else
                begin
                    dot_reg    <= dot_next;
                    norm_a_reg <= norm_a_next;
                    norm_b_reg <= norm_b_next;
                end
            end
        end
    end

    // Product registers carry payload only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_ab_reg <= elem_a * elem_b;
            prod_aa_reg <= aa_s;
            prod_bb_reg <= bb_s;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cse_fifo.sv =====
// Short queue of finished vector sums between front and back end.
// Entry type and depth come from cse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cse_fifo
    import cse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_en,
    input  wire cse_vec_t wr_data,
    output logic          full,
    input  wire logic     rd_en,
    output cse_vec_t      rd_data,
    output logic          empty
);

    cse_vec_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W:0]       count_reg;
    logic                 do_wr;
    logic                 do_rd;

    assign full    = (count_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cse_back.sv =====
// Back end: two digit-by-digit square roots, one multiply, restoring divide.
// Holds the finished result in an output register; uses cse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cse_back
    import cse_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_empty,
    input  wire cse_vec_t        q_data,
    output logic                 q_pop,
    output logic                 empty,
    input  wire logic            pop,
    output logic signed [SIM_W-1:0] similarity,
    output logic                 zero_norm
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROOT = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]          state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                neg_reg;
    logic                zero_reg;
    logic                sat_reg;
    logic [ACC_W-1:0]    mag_reg;
    logic [ACC_W-1:0]    na_sh_reg;
    logic [ACC_W-1:0]    nb_sh_reg;
    logic [REM_W-1:0]    rem_a_reg;
    logic [REM_W-1:0]    rem_b_reg;
    logic [ROOT_W-1:0]   root_a_reg;
    logic [ROOT_W-1:0]   root_b_reg;
    logic [ACC_W-1:0]    den_reg;
    logic [DIV_W-1:0]    div_rem_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic                res_valid_reg;
    logic [SIM_W-1:0]    res_sim_reg;
    logic                res_zero_reg;

    logic [REM_W+ROOT_W-1:0] step_a;
    logic [REM_W+ROOT_W-1:0] step_b;
    logic                    div_ge;
    logic [DIV_W-1:0]        div_diff;
    logic [SIM_W-1:0]        q_mag;
    logic [SIM_W-1:0]        sim_value;
    logic                    res_load;
    logic [ACC_W-1:0]        in_mag;

    // One root digit: bring down two bits, try subtracting 4*root+1
    function automatic logic [REM_W+ROOT_W-1:0] root_step(
        input logic [REM_W-1:0]  rem,
        input logic [ROOT_W-1:0] root,
        input logic [1:0]        pair
    );
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_out;
        logic [ROOT_W-1:0] root_out;
        cur   = {rem[REM_W-3:0], pair};
        trial = REM_W'({root, 2'b01});
        if (cur >= trial)
        begin
            rem_out  = cur - trial;
            root_out = {root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_out  = cur;
            root_out = {root[ROOT_W-2:0], 1'b0};
        end
        return {rem_out, root_out};
    endfunction

    assign step_a = root_step(rem_a_reg, root_a_reg, na_sh_reg[ACC_W-1 -: 2]);
    assign step_b = root_step(rem_b_reg, root_b_reg, nb_sh_reg[ACC_W-1 -: 2]);

    assign div_ge   = (div_rem_reg >= {1'b0, den_reg});
    assign div_diff = div_ge ? (div_rem_reg - {1'b0, den_reg}) : div_rem_reg;

    assign in_mag = q_data.dot[ACC_W-1] ? (~q_data.dot + 1'b1) : q_data.dot;

    always_comb
    begin
        if (sat_reg || ({1'b0, quot_reg} > Q14_ONE))
        begin
            q_mag = Q14_ONE;
        end
        else
        begin
            q_mag = {1'b0, quot_reg};
        end
        if (zero_reg)
        begin
            sim_value = '0;
        end
        else
        begin
            sim_value = neg_reg ? (~q_mag + 1'b1) : q_mag;
        end
    end

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign res_load = (state_reg == ST_OUT) && (!res_valid_reg || pop);

    assign empty      = !res_valid_reg;
    assign similarity = res_sim_reg;
    assign zero_norm  = res_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        if ((q_data.norm_a == '0) || (q_data.norm_b == '0))
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_ROOT;
                        end
                    end
                end
                ST_ROOT:
                begin
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    state_reg <= ({1'b0, mag_reg} >= {den_reg, 1'b0}) ? ST_OUT : ST_DIV;
                end
                ST_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (res_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers carry payload only
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                neg_reg    <= q_data.dot[ACC_W-1];
                mag_reg    <= in_mag;
                zero_reg   <= (q_data.norm_a == '0) || (q_data.norm_b == '0);
                sat_reg    <= 1'b0;
                na_sh_reg  <= q_data.norm_a;
                nb_sh_reg  <= q_data.norm_b;
                rem_a_reg  <= '0;
                rem_b_reg  <= '0;
                root_a_reg <= '0;
                root_b_reg <= '0;
                step_reg   <= STEP_W'(ROOT_W - 1);
            end
            ST_ROOT:
            begin
                {rem_a_reg, root_a_reg} <= step_a;
                {rem_b_reg, root_b_reg} <= step_b;
                na_sh_reg <= {na_sh_reg[ACC_W-3:0], 2'b00};
                nb_sh_reg <= {nb_sh_reg[ACC_W-3:0], 2'b00};
                step_reg  <= step_reg - 1'b1;
            end
            ST_MUL:
            begin
                den_reg <= root_a_reg * root_b_reg;
            end
            ST_CHK:
            begin
                sat_reg     <= ({1'b0, mag_reg} >= {den_reg, 1'b0});
                div_rem_reg <= {1'b0, mag_reg};
                quot_reg    <= '0;
                step_reg    <= STEP_W'(QUOT_W - 1);
            end
            ST_DIV:
            begin
                div_rem_reg <= {div_diff[DIV_W-2:0], 1'b0};
                quot_reg    <= {quot_reg[QUOT_W-2:0], div_ge};
                step_reg    <= step_reg - 1'b1;
            end
            ST_OUT:
            begin
                if (res_load)
                begin
                    res_sim_reg  <= sim_value;
                    res_zero_reg <= zero_reg;
                end
            end
            default:
            begin
                step_reg <= '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/cosine_similarity_engine_unit.sv =====
// Top level of the cosine similarity engine: configuration register and wiring.
// Instantiates cse_front, cse_fifo and cse_back; uses cse_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------
//  input     | push / full          | elem_a, elem_b (signed Q1.14 pair)
//  result    | empty / pop          | similarity (signed Q1.14), zero_norm
//  config    | psel/penable/pwrite  | paddr, pwdata, prdata (vector_length)
//
//  Element pairs are taken one per cycle while full is low. The back end works,
//  per vector, through 20 root digits, one multiply, one range check, 15 quotient
//  bits, load and fetch; it skips the divide when the ratio is two or more and
//  goes straight to the load when a norm is zero, so short vectors run at the
//  back end's pace.
//  Reset clears the accumulators, the pair count and the queue, and sets
//  vector_length to 512. full rises only when a finished vector meets a full
//  queue; a result left unpopped stalls the back end after one more vector.

module cosine_similarity_engine_unit
    import cse_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // input channel
    input  wire logic                     push,
    output logic                          full,
    input  wire logic signed [ELEM_W-1:0] elem_a,
    input  wire logic signed [ELEM_W-1:0] elem_b,
    // result channel
    output logic                          empty,
    input  wire logic                     pop,
    output logic signed [SIM_W-1:0]       similarity,
    output logic                          zero_norm,
    // configuration port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready
);

    logic [LEN_W-1:0] vector_length_reg;
    logic             cfg_write;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    cse_vec_t         q_wr_data;
    cse_vec_t         q_rd_data;

    // Register file: a single register at word index zero
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_VECTOR_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= LEN_RESET;
        end
        else if (cfg_write)
        begin
            vector_length_reg <= pwdata[LEN_W-1:0];
        end
    end

    // Read back the register; unmapped words read as zero
    assign prdata = (paddr[2] == REG_VECTOR_LENGTH) ? DATA_W'(vector_length_reg) : '0;

    // Accumulate pairs and hand over each finished vector
    cse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .elem_a        (elem_a),
        .elem_b        (elem_b),
        .vector_length (vector_length_reg),
        .q_push        (q_push),
        .q_data        (q_wr_data),
        .q_full        (q_full)
    );

    // Decouple the accumulator from the divide so each can stall on its own
    cse_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // Roots, denominator and quotient; hold the result until transferred
    cse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_rd_data),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .similarity (similarity),
        .zero_norm  (zero_norm)
    );

endmodule

`default_nettype wire

// ===== verif/cse_checker.sv =====
// Checker for the cosine similarity engine: predicts each result and compares it.
// Watches the input, result and configuration channels; uses cse_pkg.
`timescale 1ns / 1ps

module cse_checker
    import cse_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic                     full,
    input  logic signed [ELEM_W-1:0] elem_a,
    input  logic signed [ELEM_W-1:0] elem_b,
    input  logic                     empty,
    input  logic                     pop,
    input  logic signed [SIM_W-1:0]  similarity,
    input  logic                     zero_norm,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    input  logic [DATA_W-1:0]        prdata,
    input  logic                     pready,
    output int                       mismatches,
    output int                       outstanding
);

    localparam int FRAC_BITS = 14;

    typedef longint unsigned u64_t;

    typedef struct {
        logic signed [SIM_W-1:0] sim;
        logic                    zero;
    } cosine_t;

    cosine_t                 cosine_q[$];
    logic signed [ACC_W-1:0] dot_sum;
    logic [ACC_W-1:0]        sq_sum_a;
    logic [ACC_W-1:0]        sq_sum_b;
    int unsigned             pairs_taken;
    logic [LEN_W-1:0]        len_reg;

    initial mismatches = 0;

    task automatic log_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Floor of the square root, one result bit at a time from the top.
    function automatic u64_t floor_root(input u64_t n);
        u64_t root;
        u64_t trial;
        root = 0;
        for (int i = ROOT_W - 1; i >= 0; i--) begin
            trial = root | (u64_t'(1) << i);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    task automatic accumulate_pair(input logic signed [ELEM_W-1:0] a,
                                   input logic signed [ELEM_W-1:0] b);
        longint      dot_next;
        u64_t        sq_a;
        u64_t        sq_b;
        u64_t        mag;
        u64_t        den;
        u64_t        quot;
        int unsigned eff_len;
        cosine_t     res;

        dot_next = longint'(dot_sum) + longint'(a) * longint'(b);
        if (dot_next > longint'(DOT_MAX))
            dot_next = longint'(DOT_MAX);
        if (dot_next < longint'(DOT_MIN))
            dot_next = longint'(DOT_MIN);
        dot_sum = ACC_W'(dot_next);

        sq_a = u64_t'(sq_sum_a) + u64_t'(longint'(a) * longint'(a));
        sq_b = u64_t'(sq_sum_b) + u64_t'(longint'(b) * longint'(b));
        sq_sum_a = (sq_a > u64_t'(NORM_MAX)) ? NORM_MAX : ACC_W'(sq_a);
        sq_sum_b = (sq_b > u64_t'(NORM_MAX)) ? NORM_MAX : ACC_W'(sq_b);

        pairs_taken++;
        // zero acts as one, anything past the longest vector as the longest
        eff_len = (len_reg == 0) ? 1 : ((len_reg > MAX_DIM) ? MAX_DIM : len_reg);
        if (pairs_taken < eff_len)
            return;

        res.zero = (sq_sum_a == 0) || (sq_sum_b == 0);
        res.sim  = '0;
        if (!res.zero) begin
            den  = floor_root(u64_t'(sq_sum_a)) * floor_root(u64_t'(sq_sum_b));
            mag  = (dot_sum < 0) ? u64_t'(-longint'(dot_sum)) : u64_t'(longint'(dot_sum));
            quot = (mag << FRAC_BITS) / den;
            // floored roots can push the ratio past one
            if (quot > u64_t'(Q14_ONE))
                quot = u64_t'(Q14_ONE);
            res.sim = (dot_sum < 0) ? -SIM_W'(quot) : SIM_W'(quot);
        end
        cosine_q.push_back(res);

        dot_sum     = '0;
        sq_sum_a    = '0;
        sq_sum_b    = '0;
        pairs_taken = 0;
    endtask

    task automatic check_result;
        cosine_t want;
        if (cosine_q.size() == 0) begin
            log_mismatch($sformatf("unexpected result similarity=%0d zero_norm=%0b",
                                   similarity, zero_norm));
            return;
        end
        want = cosine_q.pop_front();
        if (similarity !== want.sim)
            log_mismatch($sformatf("similarity %0d, predicted %0d", similarity, want.sim));
        if (zero_norm !== want.zero)
            log_mismatch($sformatf("zero_norm %0b, predicted %0b", zero_norm, want.zero));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dot_sum     = '0;
            sq_sum_a    = '0;
            sq_sum_b    = '0;
            pairs_taken = 0;
            len_reg     = LEN_RESET;
            cosine_q.delete();
        end
        else begin
            // a result leaving now was caused by earlier pairs
            if (pop && !empty)
                check_result();
            if (push && !full)
                accumulate_pair(elem_a, elem_b);
            if (psel && penable && pready && paddr[2] == REG_VECTOR_LENGTH) begin
                if (pwrite)
                    len_reg = pwdata[LEN_W-1:0];
                else if (prdata !== DATA_W'(len_reg))
                    log_mismatch($sformatf("vector_length read %0d, held %0d",
                                           prdata, len_reg));
            end
        end
        outstanding = cosine_q.size();
    end

endmodule

// ===== verif/tb_cosine_similarity_engine_unit.sv =====
// Testbench top for the cosine similarity engine: clock, reset, stimulus, verdict.
// Instantiates cosine_similarity_engine_unit and cse_checker; uses cse_pkg.
`timescale 1ns / 1ps

module tb_cosine_similarity_engine_unit;
    import cse_pkg::*;

    localparam int HALF_PERIOD_NS  = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int IDLE_PCT        = 19;
    // let the back end finish its last vector; allow a margin on top
    localparam int SETTLE_CYCLES   = 60;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_ITEMS    = 380;
    localparam int PRESSURE_PHASE  = 2;
    localparam int PRESSURE_ITEMS  = 40;
    // windows with no idling on either side
    localparam int TX_QUIET_FROM   = 150;
    localparam int TX_QUIET_TO     = 270;
    localparam int RX_QUIET_FROM   = 1500;
    localparam int RX_QUIET_TO     = 3500;
    localparam longint LIMIT_NS    = 64'd10_000_000;

    localparam logic [ADDR_W-1:0]        LEN_ADDR = {REG_VECTOR_LENGTH, 2'b00};
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
    localparam logic [LEN_W-1:0]         LEN_TOP  = {LEN_W{1'b1}};

    // shape of the element pairs within one phase
    typedef enum int {
        MIX_FULL,
        MIX_A_ZERO,
        MIX_B_ZERO,
        MIX_SAME,
        MIX_OPPOSITE,
        MIX_EXTREME,
        MIX_TINY,
        MIX_COUNT
    } mix_e;

    logic                     clk;
    logic                     rst_n;
    logic                     push;
    logic                     full;
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     empty;
    logic                     pop;
    logic signed [SIM_W-1:0]  similarity;
    logic                     zero_norm;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    int mismatches;
    int outstanding;
    int pairs_sent;
    bit hold_req;

    cosine_similarity_engine_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .elem_a     (elem_a),
        .elem_b     (elem_b),
        .empty      (empty),
        .pop        (pop),
        .similarity (similarity),
        .zero_norm  (zero_norm),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    cse_checker u_checker (.*);

    initial clk = 1'b0;
    always #HALF_PERIOD_NS clk = ~clk;

    // Watchdog: end the run if the block hangs.
    initial
    begin
        #LIMIT_NS;
        $display("tb: failure");
        $finish;
    end

    // Offer one pair and hold it until the block takes it. Entered and left at a
    // falling edge; push is left high so back-to-back transfers stay gapless.
    task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                             input logic signed [ELEM_W-1:0] b);
        while (!(pairs_sent >= TX_QUIET_FROM && pairs_sent < TX_QUIET_TO)
               && $urandom_range(0, 99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push   <= 1'b1;
        elem_a <= a;
        elem_b <= b;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
        pairs_sent++;
    endtask

    // Wait for every predicted result to drain, then let the back end go quiet.
    task automatic settle;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // A setup phase and an access phase on the register port, then psel drops before
    // the task returns so that the next transfer never lowers and raises psel in one step.
    task automatic apb_access(input logic write, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= LEN_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Drop push, drain the block, write the length (junk in the upper bits) and
    // read it back for the checker.
    task automatic set_length(input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] word;
        push <= 1'b0;
        settle();
        word = $urandom;
        word[LEN_W-1:0] = len;
        apb_access(1'b1, word);
        apb_access(1'b0, '0);
    endtask

    function automatic void mix_pair(input mix_e mix,
                                     output logic signed [ELEM_W-1:0] a,
                                     output logic signed [ELEM_W-1:0] b);
        logic signed [ELEM_W-1:0] corner [5];
        corner = '{ELEM_MIN, -16'sd1, 16'sd0, 16'sd1, ELEM_MAX};
        a = ELEM_W'($urandom);
        b = ELEM_W'($urandom);
        case (mix)
            MIX_A_ZERO:   a = '0;
            MIX_B_ZERO:   b = '0;
            MIX_SAME:     b = a;
            MIX_OPPOSITE: b = -a;
            MIX_EXTREME:
            begin
                a = corner[$urandom_range(0, 4)];
                b = corner[$urandom_range(0, 4)];
            end
            // tiny values make the floored roots fall short, so the ratio often saturates
            MIX_TINY:
            begin
                a = ELEM_W'(int'($urandom_range(0, 6)) - 3);
                b = $urandom_range(0, 1) ? a : ELEM_W'(int'($urandom_range(0, 6)) - 3);
            end
            default: ;
        endcase
    endfunction

    // Result side: pop at random, with one long hold-off on request and a quiet
    // window in which every offered result is taken at once.
    initial
    begin : receiver
        int rx_cycle;
        rx_cycle = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (hold_req)
            begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            pop <= (rx_cycle >= RX_QUIET_FROM && rx_cycle < RX_QUIET_TO)
                   || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    initial
    begin : stimulus
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        logic [LEN_W-1:0]         len;
        mix_e                     mix;
        int unsigned              eff;
        int unsigned              count;
        int unsigned              roll;
        int                       phase;
        int                       random_from;

        rst_n      = 1'b0;
        push       = 1'b0;
        elem_a     = '0;
        elem_b     = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        hold_req   = 1'b0;
        pairs_sent = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Read back the reset length, then start a vector under it: three pairs
        // of a 512-long vector give nothing.
        apb_access(1'b0, '0);
        send_pair(ELEM_MAX, ELEM_MAX);
        send_pair(ELEM_MIN, ELEM_MIN);
        send_pair(16'sd0, 16'sd0);

        // Shorten the length below the pairs already taken: the next pair ends it.
        set_length(2);
        send_pair(16'sd1, -16'sd1);

        // Zero length acts as one: each pair is a vector. Cover a zero norm on
        // either side, both sides, and full-scale opposite signs.
        set_length(0);
        send_pair(16'sd0, 16'sd5);
        send_pair(16'sd7, 16'sd0);
        send_pair(ELEM_MIN, ELEM_MAX);
        send_pair(16'sd0, 16'sd0);

        set_length(1);
        send_pair(16'sd100, -16'sd100);
        send_pair(-16'sd1, ELEM_MAX);

        // Two-pair vectors: ratio above one in both directions, then extremes.
        set_length(2);
        send_pair(16'sd1, 16'sd1);
        send_pair(16'sd1, 16'sd1);
        send_pair(16'sd1, -16'sd1);
        send_pair(16'sd1, -16'sd1);
        send_pair(ELEM_MAX, ELEM_MIN);
        send_pair(ELEM_MIN, ELEM_MAX);

        set_length(3);
        send_pair(ELEM_MIN, 16'sd0);
        send_pair(16'sd0, ELEM_MIN);
        send_pair(16'sd16384, 16'sd16384);

        // Random phases: mostly short vectors with a random pair shape, sometimes
        // a long length that is changed again mid-vector.
        phase = 0;
        random_from = pairs_sent;
        while (pairs_sent - random_from < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                len = 0;
            else if (roll < 70)
                len = $urandom_range(1, 8);
            else if (roll < 88)
                len = $urandom_range(9, 40);
            else if (roll < 94)
                len = $urandom_range(0, 1) ? LEN_W'(MAX_DIM) : LEN_TOP;
            else
                len = $urandom_range(41, LEN_TOP);
            mix = mix_e'($urandom_range(0, MIX_COUNT - 1));
            if (phase == PRESSURE_PHASE)
            begin
                len = 1;
                mix = MIX_FULL;
            end
            eff = (len == 0) ? 1 : ((len > MAX_DIM) ? MAX_DIM : len);
            if (phase == PRESSURE_PHASE)
                count = PRESSURE_ITEMS;
            else if (eff <= 40)
                count = eff * $urandom_range(1, 3) + $urandom_range(0, 2);
            else
                count = $urandom_range(1, 20);

            set_length(len);
            // Hold the result side off while one-pair vectors keep coming, so the
            // queue fills and full stalls the input.
            if (phase == PRESSURE_PHASE)
                hold_req = 1'b1;
            repeat (count)
            begin
                mix_pair(mix, a, b);
                send_pair(a, b);
            end
            phase++;
        end

        push <= 1'b0;
        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
